// ===== rtl/ibps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibps_pkg
// Shared constants, register codes and controller types for the border pad
// scatter core.
// ----------------------------------------------------------------------------
package ibps_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_BORDER = 7;
    localparam int PIXEL_BITS = 16;

    localparam int POS_W  = 11;
    localparam int CNT_W  = 10;
    localparam int BRD_W  = 3;
    localparam int CFG_W  = 11;
    localparam int IDX_W  = 2;
    localparam int DATA_W = 40;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_BORDER_SIZE  = 2'd2;
    localparam logic [IDX_W-1:0] REG_PAD_MODE     = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic advance;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/ibps_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibps_ctrl
// Controller: takes a pixel, walks its positions one per cycle unless stalled.
// ----------------------------------------------------------------------------
module ibps_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output ibps_pkg::dp_cmd_t        cmd,
    input  wire ibps_pkg::dp_status_t status
);
    import ibps_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_tready && status.last && !s_tvalid) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.advance = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_EMIT: begin
                m_tvalid    = 1'b1;
                cmd.advance = m_tready;
                s_tready    = m_tready && status.last;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
        cmd.load = s_tvalid && s_tready;
    end

endmodule
`default_nettype wire

// ===== rtl/ibps_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibps_dp
// Datapath: configuration registers, raster counters, span set-up and the
// padded position walker.
// ----------------------------------------------------------------------------
module ibps_dp (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [ibps_pkg::IDX_W-1:0]          cfg_index,
    input  wire logic [ibps_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic signed [ibps_pkg::PIXEL_BITS-1:0] pixel_value,
    input  wire ibps_pkg::dp_cmd_t                   cmd,
    output ibps_pkg::dp_status_t                     status,
    output logic [ibps_pkg::POS_W-1:0]               out_row,
    output logic [ibps_pkg::POS_W-1:0]               out_col,
    output logic signed [ibps_pkg::PIXEL_BITS-1:0]   out_value
);
    import ibps_pkg::*;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [BRD_W-1:0] border_reg;
    logic             mode_reg;
    logic [CNT_W-1:0] col_reg,  col_next;
    logic [CNT_W-1:0] row_reg,  row_next;

    logic [POS_W-1:0] i_reg, j_reg;
    logic [POS_W-1:0] r1_reg, c0_reg, c1_reg;
    logic [POS_W-1:0] own_r_reg, own_c_reg;
    logic signed [PIXEL_BITS-1:0] pix_reg;

    logic [CFG_W-1:0] w_sat, h_sat;
    logic [POS_W-1:0] wm1, hm1, c_pos, r_pos, bw;
    logic [POS_W-1:0] r0_new, r1_new, c0_new, c1_new;
    logic [POS_W-1:0] own_r_new, own_c_new;
    logic             last_col, last_row;

    always_comb begin
        priority if (width_reg < CFG_W'(2)) begin
            w_sat = CFG_W'(2);
        end else if (width_reg > CFG_W'(MAX_WIDTH)) begin
            w_sat = CFG_W'(MAX_WIDTH);
        end else begin
            w_sat = width_reg;
        end
        priority if (height_reg < CFG_W'(2)) begin
            h_sat = CFG_W'(2);
        end else if (height_reg > CFG_W'(MAX_HEIGHT)) begin
            h_sat = CFG_W'(MAX_HEIGHT);
        end else begin
            h_sat = height_reg;
        end
        wm1   = POS_W'(w_sat - CFG_W'(1));
        hm1   = POS_W'(h_sat - CFG_W'(1));
        c_pos = (POS_W'(col_reg) >= wm1) ? wm1 : POS_W'(col_reg);
        r_pos = (POS_W'(row_reg) >= hm1) ? hm1 : POS_W'(row_reg);
        bw    = POS_W'(border_reg);
        last_col  = (c_pos == wm1);
        last_row  = (r_pos == hm1);
        own_r_new = r_pos + bw;
        own_c_new = c_pos + bw;

        priority if (r_pos == '0) begin
            r0_new = '0;
            r1_new = bw;
        end else if (last_row) begin
            r0_new = own_r_new;
            r1_new = own_r_new + bw;
        end else begin
            r0_new = own_r_new;
            r1_new = own_r_new;
        end
        priority if (c_pos == '0) begin
            c0_new = '0;
            c1_new = bw;
        end else if (last_col) begin
            c0_new = own_c_new;
            c1_new = own_c_new + bw;
        end else begin
            c0_new = own_c_new;
            c1_new = own_c_new;
        end

        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : CNT_W'(r_pos + POS_W'(1));
        end else begin
            col_next = CNT_W'(c_pos + POS_W'(1));
            row_next = CNT_W'(r_pos);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(MAX_WIDTH);
            height_reg <= CFG_W'(MAX_HEIGHT);
            border_reg <= BRD_W'(1);
            mode_reg   <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    REG_BORDER_SIZE:  border_reg <= cfg_data[BRD_W-1:0];
                    REG_PAD_MODE:     mode_reg   <= cfg_data[0];
                    default:          mode_reg   <= mode_reg;
                endcase
            end
            if (cmd.load) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            i_reg     <= r0_new;
            j_reg     <= c0_new;
            r1_reg    <= r1_new;
            c0_reg    <= c0_new;
            c1_reg    <= c1_new;
            own_r_reg <= own_r_new;
            own_c_reg <= own_c_new;
            pix_reg   <= pixel_value;
        end else if (cmd.advance) begin
            if (j_reg == c1_reg) begin
                j_reg <= c0_reg;
                i_reg <= i_reg + POS_W'(1);
            end else begin
                j_reg <= j_reg + POS_W'(1);
            end
        end
    end

    always_comb begin
        status.last = (i_reg == r1_reg) && (j_reg == c1_reg);
        out_row     = i_reg;
        out_col     = j_reg;
        if (mode_reg && !((i_reg == own_r_reg) && (j_reg == own_c_reg))) begin
            out_value = '0;
        end else begin
            out_value = pix_reg;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/image_border_pad_scatter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// image_border_pad_scatter_core
// Edge-replicate (or zero) border padding that scatters each raster pixel to
// every padded position it owns.
//
// Input stream: one pixel per item on s_tdata, in raster order.
// Output stream: one padded position per item (row, column, value); m_tlast
// marks the last position belonging to the current pixel.
// Configuration: cfg_valid/cfg_ready write channel, always ready; write only
// while the core is idle. Index 0 width, 1 height, 2 border, 3 pad mode.
// Latency: first result is presented the cycle after the pixel is taken.
// Throughput: the single position walker emits one padded position per cycle
// while m_tready is high; an interior pixel owns a single position.
// The next pixel is taken in the same cycle the last result is taken.
// Reset: raster position returns to the first pixel, registers to defaults.
// Stall: with m_tready low the current result holds and no pixel is taken.
// ----------------------------------------------------------------------------
module image_border_pad_scatter_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,   // [15:0] pixel_value
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [ibps_pkg::DATA_W-1:0]        m_tdata,   // [10:0] out_row,
                                                          // [21:11] out_col,
                                                          // [37:22] out_value
    output logic                               m_tlast,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ibps_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [ibps_pkg::CFG_W-1:0]    cfg_data
);
    import ibps_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [POS_W-1:0]             out_row, out_col;
    logic signed [PIXEL_BITS-1:0] out_value;

    assign cfg_ready = 1'b1;

    ibps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    ibps_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_value (s_tdata[PIXEL_BITS-1:0]),
        .cmd         (cmd),
        .status      (status),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_value   (out_value)
    );

    assign m_tdata = {2'b00, out_value, out_col, out_row};
    assign m_tlast = status.last;

endmodule
`default_nettype wire
